/* rtl/first_fit_block_allocator_unit_macros.svh */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_macros.svh
// Assertion macros for the block allocator. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define FFBA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffba assertion failed");
// next-cycle implication
`define FFBA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffba assertion failed");
`else
`define FFBA_ASSERT_IMP(name, ante, cons)
`define FFBA_ASSERT_NXT(name, ante, cons)
`endif

`endif

/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared codes and the result word of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_ARRAY  = 2'd2,
    ACT_RESIZE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FAIL  = 2'd1,
    ST_KEPT  = 2'd2,
    ST_FREED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_START = 1'b0,
    CFG_HEAP_END   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] copy_bytes;
    logic [31:0] copy_source;
    logic        zero_needed;
    status_e     status;
    logic [31:0] result_address;
  } result_t;

endpackage

`default_nettype wire

/* rtl/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/ffba_out_reg.sv */
// ----------------------------------------------------------------------------
// ffba_out_reg
// One-word output register; decouples the result stream from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire ffba_pkg::result_t res_i,
  output logic                  ready_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [95:0]           m_tdata_o,   // result_address, copy_source, copy_bytes
  output logic [7:0]            m_tuser_o    // status[1:0], zero_needed[2], zeros
);

  logic              valid_q;
  ffba_pkg::result_t data_q;

  assign ready_o = !valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {data_q.copy_bytes, data_q.copy_source, data_q.result_address};
  assign m_tuser_o  = {5'd0, data_q.zero_needed, data_q.status};

endmodule

`default_nettype wire

/* rtl/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap allocator over an address-ordered block table with a break.
//
// Each request word (allocate, free, zeroed array allocate, resize) yields
// exactly one result word. The block table (base, size, free flag per entry)
// lives in one synchronous RAM read one entry per cycle, so latency is set by
// the table scan over the current blocks (at most MAX_BLOCKS); a resize that
// must move scans the table twice. Requests are handled one at a time; a new
// request is taken as soon as the previous one has left the sequencer, even
// while its result still waits in the output register.
// Blocks are never split; a free of the last block pops it and pulls the
// break back. Zero fill and data copy are left to the host (zero_needed,
// copy_source, copy_bytes). The table RAM is not cleared: only entries below
// the block count are ever used. Configuration writes are taken while the
// sequencer is idle; writing heap_start also moves the break when the table
// is empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_unit_macros.svh"

module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 32,
  parameter int ADDR_BITS    = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [95:0]                    s_axis_tdata,  // byte_count, element_count,
                                                             // block_address
  input  wire logic [7:0]                     s_axis_tuser,  // action[1:0], zeros
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [95:0]                         m_axis_tdata,  // result_address, copy_source,
                                                             // copy_bytes
  output logic [7:0]                          m_axis_tuser,  // status[1:0], zero_needed[2],
                                                             // zeros
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);

  // stored addresses never exceed 32 bits (break is bounded by heap_end)
  localparam int BASE_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W  = BASE_W + 33;          // {base, size, free}
  localparam logic [33:0] HDR       = 34'(HEADER_BYTES);
  localparam logic [33:0] ADDR_MASK =
    (ADDR_BITS >= 34) ? {34{1'b1}} : ((34'd1 << ADDR_BITS) - 34'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MCHK,
    S_ASCAN,
    S_APPEND,
    S_FSCAN,
    S_ARESTART,
    S_FREEIDX
  } state_e;
  // S_DONE folded as a flag below keeps enum small
  state_e state_q;
  logic   done_q;   // result in res_q waits for the output register

  ffba_pkg::action_e act_q;
  logic [31:0]       bytes_q, elems_q, addr_q, req_q;
  logic [63:0]       prod_q, prod_d;
  logic [IDX_W-1:0]  idx_q, fidx_q;
  logic [BASE_W-1:0] fbase_q, brk_q;
  logic [31:0]       fsize_q, hend_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              mv_q;     // resize move: free the old block after alloc
  ffba_pkg::result_t res_q, res_fail;

  // table RAM
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [BASE_W-1:0] rd_base;
  logic [31:0]       rd_size;
  logic              rd_free;

  logic [33:0] rd_user_raw, rd_user, brk_user, top, fend;
  logic        fit_hit, find_hit, scan_last, app_ok, pop;
  logic        ob_ready, accept, cfg_we;

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_base = ram_rdata[ENT_W-1:33];
  assign rd_size = ram_rdata[32:1];
  assign rd_free = ram_rdata[0];

  assign s_axis_tready = (state_q == S_IDLE) && !done_q;
  assign cfg_ready_o   = (state_q == S_IDLE) && !done_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;

  // datapath: one entry compare per cycle, one add/compare for append/pop
  assign rd_user_raw = 34'(rd_base) + HDR;
  assign rd_user     = rd_user_raw & ADDR_MASK;
  assign brk_user    = (34'(brk_q) + HDR) & ADDR_MASK;
  assign fit_hit     = rd_free && (rd_size >= req_q);
  assign find_hit    = (rd_user_raw == 34'(addr_q));
  assign scan_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign top         = 34'(brk_q) + HDR + 34'(req_q);
  assign app_ok      = (cnt_q < CNT_W'(MAX_BLOCKS)) && (top <= 34'(hend_q)) &&
                       ((top >> ADDR_BITS) == 34'd0);
  assign fend        = 34'(fbase_q) + HDR + 34'(fsize_q);
  assign pop         = ((CNT_W'(fidx_q) + CNT_W'(1)) == cnt_q) && (fend == 34'(brk_q));
  assign prod_d      = 64'(elems_q) * 64'(bytes_q);

  assign res_fail = '{copy_bytes: 32'd0, copy_source: 32'd0, zero_needed: 1'b0,
                      status: ffba_pkg::ST_FAIL, result_address: 32'd0};

  // RAM ports: reads run ahead by one entry during scans, entry 0 otherwise.
  // Writes only happen in states that never feed a read used next cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {rd_base, rd_size, 1'b0};
    ram_raddr = '0;
    unique case (state_q)
      S_ASCAN: begin
        ram_raddr = idx_q + IDX_W'(1);
        ram_we    = fit_hit;
      end
      S_FSCAN: begin
        ram_raddr = idx_q + IDX_W'(1);
      end
      S_APPEND: begin
        ram_we    = app_ok;
        ram_waddr = cnt_q[IDX_W-1:0];
        ram_wdata = {brk_q, req_q, 1'b0};
      end
      S_FREEIDX: begin
        ram_we    = !pop;
        ram_waddr = fidx_q;
        ram_wdata = {fbase_q, fsize_q, 1'b1};
      end
      S_IDLE, S_MUL, S_MCHK, S_ARESTART: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffba_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (done_q && ob_ready),
    .res_i      (res_q),
    .ready_o    (ob_ready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      brk_q   <= '0;
      hend_q  <= 32'd1048576;
      mv_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (done_q && ob_ready) begin
        done_q <= 1'b0;
      end

      if (cfg_we) begin
        unique case (ffba_pkg::cfg_reg_e'(cfg_index_i))
          ffba_pkg::CFG_HEAP_START: begin
            if (cnt_q == '0) begin
              brk_q <= cfg_data_i[BASE_W-1:0];
            end
          end
          ffba_pkg::CFG_HEAP_END: hend_q <= cfg_data_i;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q   <= ffba_pkg::action_e'(s_axis_tuser[1:0]);
            bytes_q <= s_axis_tdata[31:0];
            elems_q <= s_axis_tdata[63:32];
            addr_q  <= s_axis_tdata[95:64];
            req_q   <= s_axis_tdata[31:0];
            mv_q    <= 1'b0;
            idx_q   <= '0;
            unique case (ffba_pkg::action_e'(s_axis_tuser[1:0]))
              ffba_pkg::ACT_FREE: begin
                if (s_axis_tdata[95:64] == 32'd0 || cnt_q == '0) begin
                  res_q        <= res_fail;
                  res_q.status <= ffba_pkg::ST_FREED;
                  done_q       <= 1'b1;
                end else begin
                  state_q <= S_FSCAN;
                end
              end
              ffba_pkg::ACT_ARRAY: state_q <= S_MUL;
              ffba_pkg::ACT_ALLOC, ffba_pkg::ACT_RESIZE: begin
                if (s_axis_tdata[31:0] == 32'd0) begin
                  // zero size: null for both allocate and resize
                  res_q  <= res_fail;
                  done_q <= 1'b1;
                end else if (s_axis_tuser[1:0] == ffba_pkg::ACT_RESIZE &&
                             s_axis_tdata[95:64] != 32'd0) begin
                  if (cnt_q == '0) begin
                    res_q  <= res_fail;
                    done_q <= 1'b1;
                  end else begin
                    state_q <= S_FSCAN;
                  end
                end else begin
                  state_q <= (cnt_q == '0) ? S_APPEND : S_ASCAN;
                end
              end
            endcase
          end
        end

        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_MCHK;
        end

        S_MCHK: begin
          if (elems_q == 32'd0 || bytes_q == 32'd0 || prod_q[63:32] != 32'd0) begin
            res_q   <= res_fail;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            req_q   <= prod_q[31:0];
            idx_q   <= '0;
            state_q <= (cnt_q == '0) ? S_APPEND : S_ASCAN;
          end
        end

        S_ARESTART: begin
          // RAM read address was entry 0 this cycle
          idx_q   <= '0;
          state_q <= S_ASCAN;
        end

        S_ASCAN: begin
          if (fit_hit) begin
            // reuse the first free block that is big enough, unsplit
            res_q                <= res_fail;
            res_q.status         <= ffba_pkg::ST_ALLOC;
            res_q.result_address <= rd_user[31:0];
            res_q.zero_needed    <= (act_q == ffba_pkg::ACT_ARRAY);
            if (mv_q) begin
              state_q <= S_FREEIDX;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else if (scan_last) begin
            state_q <= S_APPEND;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        S_APPEND: begin
          if (app_ok) begin
            cnt_q                <= cnt_q + CNT_W'(1);
            brk_q                <= top[BASE_W-1:0];
            res_q                <= res_fail;
            res_q.status         <= ffba_pkg::ST_ALLOC;
            res_q.result_address <= brk_user[31:0];
            res_q.zero_needed    <= (act_q == ffba_pkg::ACT_ARRAY);
            if (mv_q) begin
              state_q <= S_FREEIDX;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else begin
            // table full or heap exhausted; old block of a move stays
            res_q   <= res_fail;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end

        S_FSCAN: begin
          if (find_hit) begin
            fidx_q  <= idx_q;
            fbase_q <= rd_base;
            fsize_q <= rd_size;
            if (act_q == ffba_pkg::ACT_FREE) begin
              state_q <= S_FREEIDX;
            end else if (rd_size >= bytes_q) begin
              res_q                <= res_fail;
              res_q.status         <= ffba_pkg::ST_KEPT;
              res_q.result_address <= addr_q;
              done_q               <= 1'b1;
              state_q              <= S_IDLE;
            end else begin
              mv_q    <= 1'b1;
              req_q   <= bytes_q;
              state_q <= S_ARESTART;
            end
          end else if (scan_last) begin
            // unknown address: free ignores it, resize fails
            res_q <= res_fail;
            if (act_q == ffba_pkg::ACT_FREE) begin
              res_q.status <= ffba_pkg::ST_FREED;
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        S_FREEIDX: begin
          // last block ending at the break pops; otherwise RAM marks it free
          if (pop) begin
            cnt_q <= cnt_q - CNT_W'(1);
            brk_q <= fbase_q;
          end
          if (act_q == ffba_pkg::ACT_FREE) begin
            res_q        <= res_fail;
            res_q.status <= ffba_pkg::ST_FREED;
          end else begin
            res_q.copy_source <= addr_q;
            res_q.copy_bytes  <= fsize_q;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `FFBA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_BLOCKS))
  `FFBA_ASSERT_IMP(a_we_states, ram_we,
    state_q == S_ASCAN || state_q == S_APPEND || state_q == S_FREEIDX)
  `FFBA_ASSERT_NXT(a_append_grows, state_q == S_APPEND && app_ok,
    brk_q > $past(brk_q) && cnt_q == $past(cnt_q) + CNT_W'(1))
  `FFBA_ASSERT_IMP(a_zero_only_alloc, m_axis_tvalid && m_axis_tuser[2],
    m_axis_tuser[1:0] == ffba_pkg::ST_ALLOC)

endmodule

`default_nettype wire
